FILE: design/johab_text_to_glyph_layers_macros.svh
// Assertion macros shared by the glyph layer checks
`ifndef JOHAB_TEXT_TO_GLYPH_LAYERS_MACROS_SVH
`define JOHAB_TEXT_TO_GLYPH_LAYERS_MACROS_SVH

// same-cycle implication, held off during reset
`define JTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("johab glyph layers: assertion failed");

// next-cycle implication, held off during reset
`define JTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("johab glyph layers: assertion failed");

`endif

FILE: design/jtg_pkg.sv
// Types, constants and font tables for the Johab text to glyph layer block
`default_nettype none
package jtg_pkg;

    localparam int CHO_SIZE  = 19;
    localparam int JUNG_SIZE = 21;
    localparam int JONG_SIZE = 27;
    localparam int CHO_SETS  = 10;
    localparam int JUNG_SETS = 2;
    localparam int FINAL_GROUP_OFS = 5;

    localparam logic [8:0] BLANK_GLYPH = 9'd319;
    localparam logic [8:0] VOWEL_BASE  = 9'(CHO_SETS * CHO_SIZE);
    localparam logic [8:0] FINAL_BASE  = 9'(CHO_SETS * CHO_SIZE + JUNG_SETS * JUNG_SIZE);

    localparam logic [0:0] CFG_HANGUL_ADV = 1'd0;
    localparam logic [0:0] CFG_ASCII_ADV  = 1'd1;

    localparam logic [8:0] ADV_RESET_HANGUL = 9'd16;
    localparam logic [8:0] ADV_RESET_ASCII  = 9'd8;

    localparam logic [4:0] CHO_MAP [0:31] = '{
        5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
        5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

    localparam logic [4:0] JUNG_MAP [0:31] = '{
        5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5,
        5'd0, 5'd0, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
        5'd0, 5'd0, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
        5'd0, 5'd0, 5'd18, 5'd19, 5'd20, 5'd21, 5'd0, 5'd0};

    localparam logic [4:0] JONG_MAP [0:31] = '{
        5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
        5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd0, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
        5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd0, 5'd0};

    localparam logic [2:0] CHO_GROUP [0:31] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd1, 3'd3, 3'd3, 3'd3, 3'd1, 3'd2, 3'd4,
        3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};

    localparam logic [1:0] JONG_GROUP [0:31] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        string_start;
        logic [15:0] start_x;
        logic [15:0] line_y;
    } t_in_item;

    typedef struct packed {
        logic        is_hangul;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [6:0]  ascii_code;
        logic [8:0]  initial_glyph;
        logic [8:0]  vowel_glyph;
        logic [8:0]  final_glyph;
        logic [1:0]  layer_count;
    } t_out_item;

    typedef struct packed {
        logic        emit;
        logic        is_hangul;
        logic [6:0]  lead;
        logic [7:0]  trail;
        logic [15:0] pos_x;
    } t_front;

    typedef struct packed {
        logic [8:0] initial_glyph;
        logic [8:0] vowel_glyph;
        logic [8:0] final_glyph;
        logic [1:0] layer_count;
    } t_layers;

endpackage
`default_nettype wire

FILE: design/jtg_in_if.sv
// Text byte input channel
`default_nettype none
interface jtg_in_if;
    logic              valid;
    logic              ready;
    jtg_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/jtg_out_if.sv
// Glyph command output channel
`default_nettype none
interface jtg_out_if;
    logic               valid;
    logic               ready;
    jtg_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/jtg_front.sv
// Pen, lead byte and advance registers, with per-byte classification
`default_nettype none
module jtg_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire jtg_pkg::t_in_item i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_idx,
    input  wire logic [7:0]        i_cfg_data,
    output jtg_pkg::t_front        o_front
);
    logic        r_lead_pending, n_lead_pending;
    logic [6:0]  r_lead_byte, n_lead_byte;
    logic [15:0] r_pen_x, n_pen_x;
    logic [7:0]  r_hangul_adv;
    logic [7:0]  r_ascii_adv;
    logic        pend_cur;
    logic [15:0] pen_cur;
    logic        take_lead;

    always_comb begin
        pend_cur  = r_lead_pending & ~i_item.string_start;
        pen_cur   = i_item.string_start ? i_item.start_x : r_pen_x;
        take_lead = ~pend_cur & i_item.text_byte[7];

        o_front.emit      = ~take_lead;
        o_front.is_hangul = pend_cur;
        o_front.lead      = r_lead_byte;
        o_front.trail     = i_item.text_byte;
        o_front.pos_x     = pen_cur;

        n_lead_pending = r_lead_pending;
        n_lead_byte    = r_lead_byte;
        n_pen_x        = r_pen_x;
        if (i_accept) begin
            if (take_lead) begin
                n_lead_pending = 1'b1;
                n_lead_byte    = i_item.text_byte[6:0];
                n_pen_x        = pen_cur;
            end else begin
                n_lead_pending = 1'b0;
                n_pen_x        = pen_cur + {8'd0, pend_cur ? r_hangul_adv : r_ascii_adv};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_byte    <= '0;
            r_pen_x        <= '0;
            r_hangul_adv   <= jtg_pkg::ADV_RESET_HANGUL[7:0];
            r_ascii_adv    <= jtg_pkg::ADV_RESET_ASCII[7:0];
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_byte    <= n_lead_byte;
            r_pen_x        <= n_pen_x;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jtg_pkg::CFG_HANGUL_ADV: r_hangul_adv <= i_cfg_data;
                    jtg_pkg::CFG_ASCII_ADV:  r_ascii_adv  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/jtg_compose.sv
// Johab code split and 10x2x3 font set glyph selection
`default_nettype none
module jtg_compose (
    input  wire logic [6:0] i_lead,
    input  wire logic [7:0] i_trail,
    output jtg_pkg::t_layers o_layers
);
    logic [4:0] cho;
    logic [4:0] jung;
    logic [4:0] jong;
    logic [3:0] grp;
    logic [1:0] jgrp;

    always_comb begin
        cho  = jtg_pkg::CHO_MAP[i_lead[6:2]];
        jung = jtg_pkg::JUNG_MAP[{i_lead[1:0], i_trail[7:5]}];
        jong = jtg_pkg::JONG_MAP[i_trail[4:0]];
        jgrp = jtg_pkg::JONG_GROUP[jung];

        o_layers.vowel_glyph = jtg_pkg::BLANK_GLYPH;
        o_layers.final_glyph = jtg_pkg::BLANK_GLYPH;
        if (jong == 5'd0) begin
            grp = {1'b0, jtg_pkg::CHO_GROUP[jung]};
            if (jung == 5'd0) begin
                o_layers.layer_count = 2'd1;
            end else begin
                o_layers.layer_count = 2'd2;
                o_layers.vowel_glyph = jtg_pkg::VOWEL_BASE + {4'd0, jung} - 9'd1;
            end
        end else begin
            grp = {1'b0, jtg_pkg::CHO_GROUP[jung]} + 4'(jtg_pkg::FINAL_GROUP_OFS);
            o_layers.layer_count = 2'd3;
            o_layers.vowel_glyph = jtg_pkg::VOWEL_BASE + 9'(jtg_pkg::JUNG_SIZE)
                                 + {4'd0, jung} - 9'd1;
            o_layers.final_glyph = jtg_pkg::FINAL_BASE + {7'd0, jgrp} * 9'(jtg_pkg::JONG_SIZE)
                                 + {4'd0, jong} - 9'd1;
        end

        if (cho == 5'd0) begin
            o_layers.initial_glyph = jtg_pkg::BLANK_GLYPH;
        end else begin
            o_layers.initial_glyph = {5'd0, grp} * 9'(jtg_pkg::CHO_SIZE)
                                   + {4'd0, cho} - 9'd1;
        end
    end
endmodule
`default_nettype wire

FILE: design/johab_text_to_glyph_layers.sv
// Top level: mixed ASCII / Johab text bytes to glyph layer draw commands
// One text byte is taken per cycle while input ready is high. Its draw command is in the
// output register in the cycle after the transfer, and input ready stays high while that
// register is empty or being emptied, so a sink that never stalls never holds back the input.
// A Johab lead byte gives no command; the byte after it completes the character. The pen
// position, lead byte and two advance registers live in the front stage; config writes go to
// index 0 (Hangul advance, reset 16) and 1 (ASCII advance, reset 8) and are taken at once.
`default_nettype none
module johab_text_to_glyph_layers (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    jtg_in_if.sink          i_text,
    jtg_out_if.source       o_glyph,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);
    jtg_pkg::t_front    front;
    jtg_pkg::t_layers   layers;
    jtg_pkg::t_out_item n_out;
    jtg_pkg::t_out_item r_out;
    logic               r_out_valid, n_out_valid;
    logic               in_ready;
    logic               accept;

    assign in_ready     = ~r_out_valid | o_glyph.ready;
    assign accept       = i_text.valid & in_ready;
    assign i_text.ready = in_ready;

    jtg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_text.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_front    (front)
    );

    jtg_compose u_compose (
        .i_lead   (front.lead),
        .i_trail  (front.trail),
        .o_layers (layers)
    );

    always_comb begin
        n_out.is_hangul = front.is_hangul;
        n_out.pos_x     = front.pos_x;
        n_out.pos_y     = i_text.data.line_y;
        if (front.is_hangul) begin
            n_out.ascii_code    = 7'd0;
            n_out.initial_glyph = layers.initial_glyph;
            n_out.vowel_glyph   = layers.vowel_glyph;
            n_out.final_glyph   = layers.final_glyph;
            n_out.layer_count   = layers.layer_count;
        end else begin
            n_out.ascii_code    = front.trail[6:0];
            n_out.initial_glyph = jtg_pkg::BLANK_GLYPH;
            n_out.vowel_glyph   = jtg_pkg::BLANK_GLYPH;
            n_out.final_glyph   = jtg_pkg::BLANK_GLYPH;
            n_out.layer_count   = 2'd0;
        end

        if (accept) begin
            n_out_valid = front.emit;
        end else begin
            n_out_valid = r_out_valid & ~o_glyph.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && front.emit) begin
            r_out <= n_out;
        end
    end

    assign o_glyph.valid = r_out_valid;
    assign o_glyph.data  = r_out;
endmodule
`default_nettype wire

FILE: design/jtg_monitor.sv
// Port-level checks for the glyph layer block, bound to the top level
`default_nettype none
`include "johab_text_to_glyph_layers_macros.svh"
module jtg_monitor (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire jtg_pkg::t_out_item i_out_data
);
    `JTG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data))

    `JTG_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    `JTG_ASSERT_NOW(a_ascii_shape, i_clk, i_rst_n, i_out_valid && !i_out_data.is_hangul,
        i_out_data.layer_count == 2'd0
        && i_out_data.initial_glyph == jtg_pkg::BLANK_GLYPH
        && i_out_data.vowel_glyph == jtg_pkg::BLANK_GLYPH
        && i_out_data.final_glyph == jtg_pkg::BLANK_GLYPH)

    `JTG_ASSERT_NOW(a_hangul_shape, i_clk, i_rst_n, i_out_valid && i_out_data.is_hangul,
        i_out_data.layer_count != 2'd0 && i_out_data.ascii_code == 7'd0)

    `JTG_ASSERT_NEXT(a_no_result_from_idle, i_clk, i_rst_n,
        !i_out_valid && !(i_in_valid && i_in_ready), !i_out_valid)
endmodule

bind johab_text_to_glyph_layers jtg_monitor u_monitor (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_text.valid),
    .i_in_ready  (i_text.ready),
    .i_out_valid (o_glyph.valid),
    .i_out_ready (o_glyph.ready),
    .i_out_data  (o_glyph.data)
);
`default_nettype wire

FILE: sim/tb_johab_text_to_glyph_layers.sv
// Testbench for johab_text_to_glyph_layers: directed table and random text checked per glyph
`timescale 1ns / 100ps
`default_nettype none
module tb_johab_text_to_glyph_layers;

    localparam int CYCLE_LIMIT     = 60000;
    localparam int INITIAL_COUNT   = 19;
    localparam int VOWEL_COUNT     = 21;
    localparam int FINAL_COUNT     = 27;
    localparam int VOWEL_FIRST     = 190;
    localparam int FINAL_FIRST     = 232;
    localparam int FINAL_SET_SHIFT = 5;
    localparam int PHASES          = 6;
    localparam int PHASE_BYTES     = 75;
    localparam logic [8:0] BLANK   = jtg_pkg::BLANK_GLYPH;
    localparam int HANGUL_STEPS [PHASES] = '{0, 255, 1, 16, 255, 128};
    localparam int ASCII_STEPS [PHASES]  = '{0, 255, 254, 8, 0, 3};

    typedef struct packed {
        jtg_pkg::t_in_item  item;
        logic               typed;
        jtg_pkg::t_out_item want;
    } t_text_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    jtg_in_if  text_if ();
    jtg_out_if glyph_if ();

    johab_text_to_glyph_layers u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (text_if),
        .o_glyph    (glyph_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Johab field to vowel index, and vowel index to initial / final font set
    int vowel_of [32] = '{0, 0, 0, 1, 2, 3, 4, 5, 0, 0, 6, 7, 8, 9, 10, 11,
                          0, 0, 12, 13, 14, 15, 16, 17, 0, 0, 18, 19, 20, 21, 0, 0};
    int initial_set_of [22] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 3, 3, 3, 1, 2, 4, 4, 4, 2, 1,
                                3, 0};
    int final_set_of [22] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0, 2, 2, 1, 1, 1, 2, 2,
                              0, 0};

    logic [15:0] pen_at;
    logic        lead_held;
    logic [6:0]  lead_bits;
    logic [7:0]  adv_hangul;
    logic [7:0]  adv_ascii;

    jtg_pkg::t_out_item glyphs_due [$];
    jtg_pkg::t_out_item glyph_want;
    bit        steady;
    int        n_mismatch = 0;
    int        n_checked = 0;
    int        n_hangul = 0;
    int        n_ascii = 0;
    int        n_bytes;
    int        n_cycles = 0;

    always #2 i_clk = ~i_clk;

    function automatic bit glyph_for_byte(input jtg_pkg::t_in_item it,
                                          output jtg_pkg::t_out_item g);
        int ci;
        int v;
        int f;
        int grp;
        g = '0;
        g.pos_y = it.line_y;
        if (it.string_start) begin
            pen_at = it.start_x;
            lead_held = 1'b0;
        end
        if (!lead_held && it.text_byte[7]) begin
            lead_bits = it.text_byte[6:0];
            lead_held = 1'b1;
            return 1'b0;
        end
        g.pos_x = pen_at;
        if (lead_held) begin
            ci = int'(lead_bits[6:2]);
            ci = (ci >= 2 && ci <= 20) ? ci - 1 : 0;
            v = vowel_of[{lead_bits[1:0], it.text_byte[7:5]}];
            f = int'(it.text_byte[4:0]);
            f = (f >= 2 && f <= 17) ? f - 1 : (f >= 19 && f <= 29) ? f - 2 : 0;
            grp = initial_set_of[v];
            g.is_hangul = 1'b1;
            g.final_glyph = BLANK;
            if (f == 0) begin
                g.layer_count = (v == 0) ? 2'd1 : 2'd2;
                g.vowel_glyph = (v == 0) ? BLANK : 9'(VOWEL_FIRST + v - 1);
            end else begin
                grp += FINAL_SET_SHIFT;
                g.layer_count = 2'd3;
                g.vowel_glyph = 9'(VOWEL_FIRST + VOWEL_COUNT + v - 1);
                g.final_glyph = 9'(FINAL_FIRST + final_set_of[v] * FINAL_COUNT + f - 1);
            end
            g.initial_glyph = (ci == 0) ? BLANK : 9'(grp * INITIAL_COUNT + ci - 1);
            lead_held = 1'b0;
            pen_at = pen_at + {8'd0, adv_hangul};
        end else begin
            g.ascii_code = it.text_byte[6:0];
            g.initial_glyph = BLANK;
            g.vowel_glyph = BLANK;
            g.final_glyph = BLANK;
            g.layer_count = 2'd0;
            pen_at = pen_at + {8'd0, adv_ascii};
        end
        return 1'b1;
    endfunction

    function automatic t_text_row plain(input logic [7:0] b, input logic s,
                                        input logic [15:0] x, input logic [15:0] y);
        t_text_row r;
        r = '0;
        r.item.text_byte = b;
        r.item.string_start = s;
        r.item.start_x = x;
        r.item.line_y = y;
        return r;
    endfunction

    function automatic t_text_row typed_row(input logic [7:0] b, input logic s,
                                            input logic [15:0] x, input logic [15:0] y,
                                            input jtg_pkg::t_out_item w);
        t_text_row r;
        r = plain(b, s, x, y);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("glyph %0d: %s", n_checked, what);
        n_mismatch++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Drop valid for random idle cycles, then present the byte, wait for the transfer and log its glyph
    task automatic send_text(input jtg_pkg::t_in_item it, input bit typed,
                             input jtg_pkg::t_out_item want);
        jtg_pkg::t_out_item g;
        while (!steady && $urandom_range(99) < 13) begin
            text_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        text_if.valid <= 1'b1;
        text_if.data <= it;
        do @(posedge i_clk); while (!text_if.ready);
        n_bytes++;
        if (glyph_for_byte(it, g))
            glyphs_due.push_back(typed ? want : g);
    endtask

    task automatic wait_glyphs_done;
        text_if.valid <= 1'b0;
        do @(posedge i_clk); while (glyphs_due.size() != 0);
    endtask

    task automatic set_advances(input logic [7:0] hangul_px, input logic [7:0] ascii_px);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= jtg_pkg::CFG_HANGUL_ADV;
        i_cfg_data <= hangul_px;
        @(posedge i_clk);
        i_cfg_idx <= jtg_pkg::CFG_ASCII_ADV;
        i_cfg_data <= ascii_px;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        adv_hangul = hangul_px;
        adv_ascii = ascii_px;
    endtask

    task automatic send_random_text(input int n_target, input int drain_at);
        int sent;
        int kind;
        jtg_pkg::t_in_item it;
        sent = 0;
        while (sent < n_target) begin
            if (sent == drain_at || sent == drain_at + 1) begin
                wait_glyphs_done();
                drain_at = -10;
            end
            kind = $urandom_range(99);
            it.string_start = ($urandom_range(11) == 0);
            it.start_x = 16'($urandom());
            it.line_y = 16'($urandom());
            if (kind < 60) begin
                it.text_byte = 8'h80 | 8'($urandom_range(127));
                send_text(it, 1'b0, '0);
                it.text_byte = 8'($urandom_range(255));
                it.string_start = 1'b0;
                send_text(it, 1'b0, '0);
                sent += 2;
            end else if (kind < 88) begin
                it.text_byte = 8'($urandom_range(127));
                send_text(it, 1'b0, '0);
                sent += 1;
            end else if (kind < 95) begin
                it.text_byte = 8'($urandom_range(255));
                send_text(it, 1'b0, '0);
                sent += 1;
            end else begin
                it.text_byte = 8'h80 | 8'($urandom_range(127));
                send_text(it, 1'b0, '0);
                it.text_byte = 8'($urandom_range(255));
                it.string_start = 1'b1;
                it.start_x = 16'($urandom());
                send_text(it, 1'b0, '0);
                sent += 2;
            end
        end
    endtask

    always @(posedge i_clk) begin
        glyph_if.ready <= steady || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && glyph_if.valid && glyph_if.ready) begin
            if (glyphs_due.size() == 0) begin
                flag_mismatch("glyph command with nothing due");
            end else begin
                glyph_want = glyphs_due.pop_front();
                check_field("is_hangul", 32'(glyph_if.data.is_hangul),
                            32'(glyph_want.is_hangul));
                check_field("pos_x", 32'(glyph_if.data.pos_x), 32'(glyph_want.pos_x));
                check_field("pos_y", 32'(glyph_if.data.pos_y), 32'(glyph_want.pos_y));
                check_field("ascii_code", 32'(glyph_if.data.ascii_code),
                            32'(glyph_want.ascii_code));
                check_field("initial_glyph", 32'(glyph_if.data.initial_glyph),
                            32'(glyph_want.initial_glyph));
                check_field("vowel_glyph", 32'(glyph_if.data.vowel_glyph),
                            32'(glyph_want.vowel_glyph));
                check_field("final_glyph", 32'(glyph_if.data.final_glyph),
                            32'(glyph_want.final_glyph));
                check_field("layer_count", 32'(glyph_if.data.layer_count),
                            32'(glyph_want.layer_count));
                n_checked++;
                if (glyph_want.is_hangul)
                    n_hangul++;
                else
                    n_ascii++;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_text_row text_rows [26];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= jtg_pkg::CFG_HANGUL_ADV;
        i_cfg_data <= '0;
        text_if.valid <= 1'b0;
        text_if.data <= '0;
        steady = 1'b0;
        n_bytes = 0;
        pen_at = '0;
        lead_held = 1'b0;
        lead_bits = '0;
        adv_hangul = 8'd16;
        adv_ascii = 8'd8;

        text_rows[0] = typed_row(8'h41, 1'b1, 16'h0000, 16'h0000,
            '{1'b0, 16'h0000, 16'h0000, 7'h41, BLANK, BLANK, BLANK, 2'd0});
        text_rows[1] = typed_row(8'h7f, 1'b0, 16'hffff, 16'hffff,
            '{1'b0, 16'h0008, 16'hffff, 7'h7f, BLANK, BLANK, BLANK, 2'd0});
        text_rows[2] = typed_row(8'h00, 1'b1, 16'hffff, 16'h1234,
            '{1'b0, 16'hffff, 16'h1234, 7'h00, BLANK, BLANK, BLANK, 2'd0});
        text_rows[3] = plain(8'h80, 1'b0, 16'h0000, 16'h0000);
        text_rows[4] = typed_row(8'h00, 1'b0, 16'h0000, 16'h0001,
            '{1'b1, 16'h0007, 16'h0001, 7'h00, BLANK, BLANK, BLANK, 2'd1});
        text_rows[5] = plain(8'hff, 1'b0, 16'h0000, 16'h0002);
        text_rows[6] = plain(8'hff, 1'b0, 16'h0000, 16'h0002);
        text_rows[7] = plain(8'h88, 1'b1, 16'h0100, 16'h0010);
        text_rows[8] = plain(8'h61, 1'b0, 16'h0000, 16'h0010);
        text_rows[9] = plain(8'h88, 1'b0, 16'h0000, 16'h0010);
        text_rows[10] = plain(8'h62, 1'b0, 16'h0000, 16'h0010);
        text_rows[11] = plain(8'h88, 1'b0, 16'h0000, 16'h0010);
        text_rows[12] = plain(8'h02, 1'b0, 16'h0000, 16'h0010);
        text_rows[13] = plain(8'h84, 1'b0, 16'h0000, 16'h0010);
        text_rows[14] = plain(8'h61, 1'b0, 16'h0000, 16'h0010);
        text_rows[15] = plain(8'hd3, 1'b0, 16'h0000, 16'h0010);
        text_rows[16] = plain(8'hbd, 1'b0, 16'h0000, 16'h0010);
        text_rows[17] = plain(8'hd1, 1'b0, 16'h0000, 16'h0010);
        text_rows[18] = plain(8'hbd, 1'b0, 16'h0000, 16'h0010);
        text_rows[19] = plain(8'h88, 1'b0, 16'h0000, 16'h0020);
        text_rows[20] = plain(8'h41, 1'b1, 16'h0200, 16'h0020);
        text_rows[21] = plain(8'h88, 1'b0, 16'h0000, 16'h0030);
        text_rows[22] = plain(8'h90, 1'b1, 16'h0300, 16'h0030);
        text_rows[23] = plain(8'h41, 1'b0, 16'h0000, 16'h0030);
        text_rows[24] = plain(8'h88, 1'b0, 16'h0000, 16'h0040);
        text_rows[25] = plain(8'h88, 1'b0, 16'h0000, 16'h0040);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (text_rows[r])
            send_text(text_rows[r].item, text_rows[r].typed, text_rows[r].want);
        wait_glyphs_done();

        for (int p = 0; p < PHASES; p++) begin
            repeat (4) @(posedge i_clk);
            set_advances(8'(HANGUL_STEPS[p]), 8'(ASCII_STEPS[p]));
            steady = (p == 3);
            send_random_text(PHASE_BYTES, (p == 1) ? 40 : -10);
            wait_glyphs_done();
        end
        steady = 1'b0;
        repeat (8) @(posedge i_clk);

        $display("ran %0d text bytes through %0d advance settings, Hangul and ASCII mixed",
                 n_bytes, PHASES + 1);
        $display("compared %0d glyph commands: %0d Hangul, %0d ASCII, %0d mismatches",
                 n_checked, n_hangul, n_ascii, n_mismatch);
        if (n_mismatch == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/jtg_pkg.sv
design/jtg_in_if.sv
design/jtg_out_if.sv
design/jtg_front.sv
design/jtg_compose.sv
design/johab_text_to_glyph_layers.sv
design/jtg_monitor.sv
sim/tb_johab_text_to_glyph_layers.sv
